FILE: design/sha1md_pkg.sv
// SHA-1 digest package: controller/datapath command types, constants.
// No dependencies; used by every module of sha1_message_digest.
`default_nettype none
package sha1md_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  localparam logic [31:0] K_CH  = 32'h5a827999;
  localparam logic [31:0] K_PAR = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
  localparam logic [31:0] K_PAR2 = 32'hca62c1d6;

  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS = 80;

  typedef enum logic [2:0] {
    SRC_IN_WORD,
    SRC_LAST_WORD,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } src_e;

  typedef enum logic [1:0] {
    RND_CH,
    RND_PAR,
    RND_MAJ,
    RND_PAR2
  } rnd_e;

  typedef enum logic [2:0] {
    S_IN,
    S_PAD,
    S_ZERO,
    S_LEN_HI,
    S_LEN_LO,
    S_COMP,
    S_ADD,
    S_FIN
  } state_e;

  typedef struct packed {
    logic push;
    src_e src;
    logic count;
    logic load_work;
    logic round;
    rnd_e stage;
    logic add_chain;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic in_full;
  } status_t;

endpackage
`default_nettype wire

FILE: design/sha1md_in_if.sv
// Input word channel of the SHA-1 digest block.
// Depends on nothing.
`default_nettype none
interface sha1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last;

  modport source (output valid, data_word, valid_bytes, last, input ready);
  modport sink (input valid, data_word, valid_bytes, last, output ready);
endinterface
`default_nettype wire

FILE: design/sha1md_out_if.sv
// Digest result channel of the SHA-1 digest block.
// Depends on nothing.
`default_nettype none
interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_h0;
  logic [31:0] digest_h1;
  logic [31:0] digest_h2;
  logic [31:0] digest_h3;
  logic [31:0] digest_h4;

  modport source (output valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                  input ready);
  modport sink (input valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                output ready);
endinterface
`default_nettype wire

FILE: design/sha1md_ctrl.sv
// SHA-1 controller: word intake, padding sequence, round counter, result handshake.
// Depends on sha1md_pkg.
`default_nettype none
module sha1md_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sha1md_pkg::status_t status_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sha1md_pkg::cmd_t       cmd_o
);
  import sha1md_pkg::*;

  state_e     state_q, state_d, ret_q, ret_d;
  logic [3:0] pos_q, pos_d;
  logic [6:0] rnd_q, rnd_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      ret_q       <= S_IN;
      pos_q       <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pos_q       <= pos_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pos_d       = pos_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.src   = SRC_ZERO;
    cmd_o.stage = RND_CH;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.count = 1'b1;
          cmd_o.push  = 1'b1;
          if (!status_i.in_last) begin
            cmd_o.src = SRC_IN_WORD;
            state_d   = S_IN;
          end else if (status_i.in_full) begin
            cmd_o.src = SRC_IN_WORD;
            state_d   = S_PAD;
          end else begin
            cmd_o.src = SRC_LAST_WORD;
            state_d   = S_ZERO;
          end
        end
      end
      S_PAD: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_PAD;
        state_d    = S_ZERO;
      end
      S_ZERO: begin
        if (pos_q == 4'd14) begin
          state_d = S_LEN_HI;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = SRC_ZERO;
          state_d    = S_ZERO;
        end
      end
      S_LEN_HI: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN_HI;
        state_d    = S_LEN_LO;
      end
      S_LEN_LO: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN_LO;
        state_d    = S_FIN;
      end
      S_COMP: begin
        cmd_o.round = 1'b1;
        if (rnd_q < 7'd20) begin
          cmd_o.stage = RND_CH;
        end else if (rnd_q < 7'd40) begin
          cmd_o.stage = RND_PAR;
        end else if (rnd_q < 7'd60) begin
          cmd_o.stage = RND_MAJ;
        end else begin
          cmd_o.stage = RND_PAR2;
        end
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(ROUNDS - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_chain = 1'b1;
        state_d         = ret_q;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          pos_d        = '0;
          state_d      = S_IN;
        end
      end
      default: state_d = S_IN;
    endcase

    // advance the fill position; a full block diverts to the rounds
    if (cmd_o.push) begin
      pos_d = pos_q + 4'd1;
      if (pos_q == 4'(BLOCK_WORDS - 1)) begin
        cmd_o.load_work = 1'b1;
        ret_d           = state_d;
        rnd_d           = '0;
        state_d         = S_COMP;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_full_block_compresses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push && pos_q == 4'd15 |=> state_q == S_COMP && rnd_q == 7'd0)
    else $error("full block did not start the rounds");
  a_add_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD |-> $past(state_q) == S_COMP && $past(rnd_q) == 7'd79)
    else $error("chaining add without eighty rounds");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("pending digest dropped");
  a_finish_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> pos_q == 4'd0)
    else $error("digest emitted mid block");
`endif
endmodule
`default_nettype wire

FILE: design/sha1md_dp.sv
// SHA-1 datapath: message schedule window, round registers, chaining words,
// bit counter and digest output register. Depends on sha1md_pkg.
`default_nettype none
module sha1md_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sha1md_pkg::cmd_t  cmd_i,
  input  wire logic [31:0]       data_word_i,
  input  wire logic [2:0]        valid_bytes_i,
  input  wire logic              last_i,
  output sha1md_pkg::status_t    status_o,
  output logic [31:0]            digest_h0_o,
  output logic [31:0]            digest_h1_o,
  output logic [31:0]            digest_h2_o,
  output logic [31:0]            digest_h3_o,
  output logic [31:0]            digest_h4_o
);
  import sha1md_pkg::*;

  logic [31:0] w_q [BLOCK_WORDS];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [63:0] cnt_q;
  logic [31:0] dig_q [5];

  logic        full;
  logic [31:0] last_word, push_word, w_new, f, k, t;
  logic [63:0] cnt_add;

  assign full = valid_bytes_i >= 3'd4;
  assign status_o.in_last = last_i;
  assign status_o.in_full = full;

  always_comb begin
    case (valid_bytes_i)
      3'd0:    last_word = {PAD_BYTE, 24'h0};
      3'd1:    last_word = {data_word_i[31:24], PAD_BYTE, 16'h0};
      3'd2:    last_word = {data_word_i[31:16], PAD_BYTE, 8'h0};
      3'd3:    last_word = {data_word_i[31:8], PAD_BYTE};
      default: last_word = data_word_i;
    endcase
    case (cmd_i.src)
      SRC_IN_WORD:   push_word = data_word_i;
      SRC_LAST_WORD: push_word = last_word;
      SRC_PAD:       push_word = PAD_WORD;
      SRC_LEN_HI:    push_word = cnt_q[63:32];
      SRC_LEN_LO:    push_word = cnt_q[31:0];
      default:       push_word = '0;
    endcase
    if (!last_i || full) begin
      cnt_add = 64'd32;
    end else begin
      cnt_add = {58'd0, valid_bytes_i, 3'd0};
    end
  end

  always_comb begin
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
    case (cmd_i.stage)
      RND_CH: begin
        f = (b_q & c_q) | (~b_q & d_q);
        k = K_CH;
      end
      RND_PAR: begin
        f = b_q ^ c_q ^ d_q;
        k = K_PAR;
      end
      RND_MAJ: begin
        f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        k = K_MAJ;
      end
      default: begin
        f = b_q ^ c_q ^ d_q;
        k = K_PAR2;
      end
    endcase
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round) begin
      for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[BLOCK_WORDS-1] <= cmd_i.round ? w_new : push_word;
    end
    if (cmd_i.load_work) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (cmd_i.round) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
    if (cmd_i.finish) begin
      for (int j = 0; j < 5; j++) begin
        dig_q[j] <= h_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= H0_INIT;
      h_q[1] <= H1_INIT;
      h_q[2] <= H2_INIT;
      h_q[3] <= H3_INIT;
      h_q[4] <= H4_INIT;
      cnt_q  <= '0;
    end else if (cmd_i.finish) begin
      h_q[0] <= H0_INIT;
      h_q[1] <= H1_INIT;
      h_q[2] <= H2_INIT;
      h_q[3] <= H3_INIT;
      h_q[4] <= H4_INIT;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.add_chain) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
      if (cmd_i.count) begin
        cnt_q <= cnt_q + cnt_add;
      end
    end
  end

  assign digest_h0_o = dig_q[0];
  assign digest_h1_o = dig_q[1];
  assign digest_h2_o = dig_q[2];
  assign digest_h3_o = dig_q[3];
  assign digest_h4_o = dig_q[4];
endmodule
`default_nettype wire

FILE: design/sha1_message_digest.sv
// Channel  Dir  Payload                                Handshake
// in_i     in   data_word[31:0] valid_bytes[2:0] last  valid/ready
// out_o    out  digest_h0..digest_h4 [31:0]            valid/ready
// One word enters per cycle while a block fills; the sixteenth word starts
// 80 rounds of the single round unit, followed by the chaining add.
// The last word adds padding words, one or two compressions and the posting
// of the digest.
// Reset loads the initial chaining words; a digest waits in its register
// for the sink while the next message already flows in.
// Depends on sha1md_pkg, sha1md_in_if, sha1md_out_if, sha1md_ctrl, sha1md_dp.
`default_nettype none
module sha1_message_digest (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sha1md_in_if.sink  in_i,
  sha1md_out_if.source out_o
);
  import sha1md_pkg::*;

  cmd_t    cmd;
  status_t status;

  sha1md_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  sha1md_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_word_i   (in_i.data_word),
    .valid_bytes_i (in_i.valid_bytes),
    .last_i        (in_i.last),
    .status_o      (status),
    .digest_h0_o   (out_o.digest_h0),
    .digest_h1_o   (out_o.digest_h1),
    .digest_h2_o   (out_o.digest_h2),
    .digest_h3_o   (out_o.digest_h3),
    .digest_h4_o   (out_o.digest_h4)
  );
endmodule
`default_nettype wire

FILE: tb/sha1md_checker.sv
// Digest checker for sha1_message_digest: watches both channels, predicts
// the SHA-1 digest of each message and compares it with the block's output.
// Depends on sha1md_pkg, sha1md_in_if, sha1md_out_if.
`default_nettype none
module sha1md_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha1md_in_if      in_i,
  sha1md_out_if     out_o,
  output int        fail_count_o,
  output int        pending_o
);
  import sha1md_pkg::*;

  typedef struct packed {
    logic [31:0] h0, h1, h2, h3, h4;
  } digest_t;

  logic [31:0] chain_q [5];
  logic [31:0] blk_q [16];
  int unsigned wpos_q;
  logic [63:0] nbits_q;
  digest_t     digest_fifo [$];

  assign pending_o = digest_fifo.size();

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic init_state();
    chain_q[0] = H0_INIT; chain_q[1] = H1_INIT; chain_q[2] = H2_INIT;
    chain_q[3] = H3_INIT; chain_q[4] = H4_INIT;
    wpos_q = 0;
    nbits_q = '0;
  endtask

  task automatic compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk_q[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K_CH;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K_PAR;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K_MAJ;
      end else begin
        f = b ^ c ^ d; k = K_PAR2;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic push(logic [31:0] wd);
    blk_q[wpos_q] = wd;
    wpos_q++;
    if (wpos_q == 16) begin
      compress();
      wpos_q = 0;
    end
  endtask

  task automatic absorb_word(logic [31:0] wd, logic [2:0] nb, logic lst);
    logic [31:0] keep;
    int unsigned n;
    digest_t     dg;
    if (!lst) begin
      nbits_q += 32;
      push(wd);
    end else begin
      n = (nb > 4) ? 4 : nb;
      nbits_q += 64'(n * 8);
      if (n == 4) begin
        push(wd);
        push(PAD_WORD);
      end else begin
        keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
        push((wd & keep) | (32'(PAD_BYTE) << (24 - 8 * n)));
      end
      if (wpos_q > 14) while (wpos_q != 0) push('0);
      while (wpos_q < 14) push('0);
      push(nbits_q[63:32]);
      push(nbits_q[31:0]);
      dg = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
      digest_fifo = {digest_fifo, dg};
      init_state();
    end
  endtask

  initial begin
    fail_count_o = 0;
    init_state();
  end

  always @(posedge clk_i) begin
    digest_t got, want;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) absorb_word(in_i.data_word, in_i.valid_bytes, in_i.last);
      if (out_o.valid && out_o.ready) begin
        got = {out_o.digest_h0, out_o.digest_h1, out_o.digest_h2, out_o.digest_h3,
               out_o.digest_h4};
        if (digest_fifo.size() == 0) begin
          $display("%0t: unexpected digest %h", $time, got);
          fail_count_o++;
        end else begin
          want = digest_fifo.pop_front();
          if (got.h0 !== want.h0) begin
            $display("%0t: h0 exp %h got %h", $time, want.h0, got.h0); fail_count_o++;
          end
          if (got.h1 !== want.h1) begin
            $display("%0t: h1 exp %h got %h", $time, want.h1, got.h1); fail_count_o++;
          end
          if (got.h2 !== want.h2) begin
            $display("%0t: h2 exp %h got %h", $time, want.h2, got.h2); fail_count_o++;
          end
          if (got.h3 !== want.h3) begin
            $display("%0t: h3 exp %h got %h", $time, want.h3, got.h3); fail_count_o++;
          end
          if (got.h4 !== want.h4) begin
            $display("%0t: h4 exp %h got %h", $time, want.h4, got.h4); fail_count_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Top of the sha1_message_digest testbench: clock, reset, word stimulus with
// random gaps and output stalls, and the verdict from sha1md_checker.
// Depends on sha1md_pkg, sha1md_in_if, sha1md_out_if, sha1md_checker.
`default_nettype none
module testbench;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   cycle_count = 0;
  bit   no_idle = 1'b0;

  sha1md_in_if  in_ch ();
  sha1md_out_if out_ch ();

  sha1_message_digest dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));
  sha1md_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
                      .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 13);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 600000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] wd, logic [2:0] nb, logic lst);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= wd;
    in_ch.valid_bytes <= nb;
    in_ch.last <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_message(int nwords, logic [2:0] nb, bit well_formed);
    for (int i = 0; i < nwords; i++)
      send_word($urandom, well_formed ? 3'd4 : 3'($urandom_range(7)), 1'b0);
    send_word($urandom, nb, 1'b1);
  endtask

  initial begin
    int sent;
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hdeadbeef, 3'd1, 1'b1);
    send_word(32'hdeadbeef, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd5, 1'b1);
    send_word(32'hffffffff, 3'd6, 1'b1);
    send_message(12, 3'd4, 1'b0);
    send_message(13, 3'd0, 1'b1);
    sent = 35;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    while (sent < 950) begin
      no_idle = (sent > 400 && sent < 550);
      case ($urandom_range(9))
        0: n = $urandom_range(40);
        1, 2: n = 13 + $urandom_range(4);
        default: n = $urandom_range(17);
      endcase
      send_message(n, 3'($urandom_range(7)), $urandom_range(9) != 0);
      sent += n + 1;
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
